[hw/rtl/cwb_pkg.sv]
// ----------------------------------------------------------------------------
// cwb_pkg: shared types and constants of the chunk window
// Window geometry, field widths, command decode and engine states.
// ----------------------------------------------------------------------------
package cwb_pkg;

	// Window geometry
	localparam int WINDOW_SLOTS = 64;
	localparam int SLOT_BITS    = $clog2(WINDOW_SLOTS);
	localparam int COUNT_BITS   = $clog2(WINDOW_SLOTS + 1);
	localparam int LENGTH_BITS  = 16;
	localparam int INDEX_BITS   = 32;
	localparam int BYTES_BITS   = 22;

	// Configuration registers
	localparam int CHUNK_SIZE_BITS = 16;
	localparam int CAPACITY_BITS   = 23;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int CFG_DATA_BITS   = 23;

	localparam logic [CFG_INDEX_BITS-1:0] REG_CHUNK_SIZE = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CAPACITY   = 2'd1;

	localparam logic [CHUNK_SIZE_BITS-1:0] CHUNK_SIZE_RESET = 16'd1;
	localparam logic [CAPACITY_BITS-1:0]   CAPACITY_RESET   = 23'd65536;

	// Command queue between front and engine
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QFILL_BITS  = $clog2(QUEUE_DEPTH + 1);

	// Function codes on the command channel
	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_READ   = 2'd1,
		OP_DROP   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                    op;
		logic [INDEX_BITS-1:0]  index;
		logic [LENGTH_BITS-1:0] length;
	} cmd_t;

	typedef struct packed {
		logic                   accepted;
		logic                   found;
		logic [LENGTH_BITS-1:0] found_length;
		logic [SLOT_BITS-1:0]   slot;
		logic [INDEX_BITS-1:0]  first_index;
		logic [COUNT_BITS-1:0]  held_count;
		logic [BYTES_BITS-1:0]  held_bytes;
		logic [COUNT_BITS-1:0]  evicted;
	} rsp_t;

	// Engine sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPEND,
		ST_EVICT,
		ST_DROP,
		ST_READ,
		ST_DONE
	} state_t;

endpackage

[hw/rtl/cwb_cmd_if.sv]
// ----------------------------------------------------------------------------
// cwb_cmd_if: command channel
// Valid/ready channel carrying one command word of the chunk window.
// ----------------------------------------------------------------------------
interface cwb_cmd_if import cwb_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [1:0]             func;
	logic [INDEX_BITS-1:0]  chunk_index;
	logic [LENGTH_BITS-1:0] chunk_length;

	modport source (output valid, output func, output chunk_index, output chunk_length,
		input ready);
	modport sink (input valid, input func, input chunk_index, input chunk_length,
		output ready);
endinterface

[hw/rtl/cwb_rsp_if.sv]
// ----------------------------------------------------------------------------
// cwb_rsp_if: result channel
// Valid/ready channel carrying one result word of the chunk window.
// ----------------------------------------------------------------------------
interface cwb_rsp_if import cwb_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   accepted;
	logic                   found;
	logic [LENGTH_BITS-1:0] found_length;
	logic [SLOT_BITS-1:0]   slot;
	logic [INDEX_BITS-1:0]  first_index;
	logic [COUNT_BITS-1:0]  held_count;
	logic [BYTES_BITS-1:0]  held_bytes;
	logic [COUNT_BITS-1:0]  evicted;

	modport source (output valid, output accepted, output found, output found_length,
		output slot, output first_index, output held_count, output held_bytes,
		output evicted, input ready);
	modport sink (input valid, input accepted, input found, input found_length,
		input slot, input first_index, input held_count, input held_bytes,
		input evicted, output ready);
endinterface

[hw/rtl/cwb_cfg_if.sv]
// ----------------------------------------------------------------------------
// cwb_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface cwb_cfg_if import cwb_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/cwb_front.sv]
// ----------------------------------------------------------------------------
// cwb_front: command intake
// Registers each incoming word, decodes its function code and hands it on
// to the command queue.
// ----------------------------------------------------------------------------
module cwb_front import cwb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	cwb_cmd_if.sink    cmd,
	output logic       push_valid,
	input  logic       push_ready,
	output cmd_t       push_cmd
);

	logic vld_s1;
	cmd_t cmd_s1;
	op_t  op_dec;
	logic take;

	// Take a new word when the stage is empty or drains this cycle
	assign cmd.ready  = !vld_s1 || push_ready;
	assign take       = cmd.valid && cmd.ready;
	assign push_valid = vld_s1;
	assign push_cmd   = cmd_s1;

	// Decode the function code
	always_comb begin
		case (cmd.func)
			OP_APPEND: op_dec = OP_APPEND;
			OP_READ:   op_dec = OP_READ;
			OP_DROP:   op_dec = OP_DROP;
			default:   op_dec = OP_CLEAR;
		endcase
	end

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.op     <= op_dec;
			cmd_s1.index  <= cmd.chunk_index;
			cmd_s1.length <= cmd.chunk_length;
		end
	end

endmodule

[hw/rtl/cwb_queue.sv]
// ----------------------------------------------------------------------------
// cwb_queue: command queue
// Small FIFO that decouples the intake from the window engine.
// ----------------------------------------------------------------------------
module cwb_queue import cwb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_cmd
);

	cmd_t                  entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]  wr_ptr_q;
	logic [QPTR_BITS-1:0]  rd_ptr_q;
	logic [QFILL_BITS-1:0] fill_q;
	logic                  push;
	logic                  pop;

	assign in_ready  = fill_q != QFILL_BITS'(QUEUE_DEPTH);
	assign out_valid = fill_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_cmd   = entry_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + QFILL_BITS'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - QFILL_BITS'(1);
			end
		end
	end

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

[hw/rtl/cwb_engine.sv]
// ----------------------------------------------------------------------------
// cwb_engine: window engine
// Executes queued commands against the chunk ring: length memory, window
// pointers, one-chunk-per-cycle eviction and the result output register.
// ----------------------------------------------------------------------------
module cwb_engine import cwb_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	output logic                     q_ready,
	input  cmd_t                     q_cmd,
	input  logic [CAPACITY_BITS-1:0] cap,
	cwb_rsp_if.source                rsp
);

	// Sequencer
	state_t state_q;
	state_t state_d;

	// Window state
	logic [SLOT_BITS-1:0]  head_q, head_d;
	logic [COUNT_BITS-1:0] count_q, count_d;
	logic [INDEX_BITS-1:0] oldest_q, oldest_d;
	logic [BYTES_BITS-1:0] total_q, total_d;

	// Per-command working registers
	logic                   accepted_q, accepted_d;
	logic                   found_q, found_d;
	logic [SLOT_BITS-1:0]   slot_q, slot_d;
	logic [COUNT_BITS-1:0]  evicted_q, evicted_d;
	logic [INDEX_BITS-1:0]  bound_q, bound_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;

	// Length memory
	logic [LENGTH_BITS-1:0] length_mem [WINDOW_SLOTS];
	logic [LENGTH_BITS-1:0] rd_q;
	logic                   rd_en;
	logic [SLOT_BITS-1:0]   rd_addr;
	logic                   wr_en;
	logic [SLOT_BITS-1:0]   tail;

	// Output register
	logic out_valid_q;
	rsp_t out_q;
	logic emit;
	logic out_free;

	// Shared conditions
	logic [INDEX_BITS-1:0] next_index;
	logic [INDEX_BITS-1:0] read_off;
	logic                  read_hit;
	logic                  ring_full;
	logic                  evict_go;
	logic                  drop_go;

	assign next_index = oldest_q + INDEX_BITS'(count_q);
	assign read_off   = q_cmd.index - oldest_q;
	assign read_hit   = read_off < INDEX_BITS'(count_q);
	assign ring_full  = count_q == COUNT_BITS'(WINDOW_SLOTS);
	assign tail       = head_q + count_q[SLOT_BITS-1:0];
	assign evict_go   = ({1'b0, total_q} > cap) && (count_q > COUNT_BITS'(1));
	assign drop_go    = (oldest_q < bound_q) && (count_q != '0);
	assign out_free   = !out_valid_q || rsp.ready;
	assign q_ready    = state_q == ST_IDLE;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_cmd.op)
						OP_APPEND: state_d = (q_cmd.index == next_index) ? ST_APPEND : ST_DONE;
						OP_READ:   state_d = ST_READ;
						OP_DROP:   state_d = ST_DROP;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_APPEND: state_d = ST_EVICT;
			ST_EVICT: begin
				if (!evict_go && out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_DROP: begin
				if (!drop_go && out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ, ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath control and next values
	always_comb begin
		head_d     = head_q;
		count_d    = count_q;
		oldest_d   = oldest_q;
		total_d    = total_q;
		accepted_d = accepted_q;
		found_d    = found_q;
		slot_d     = slot_q;
		evicted_d  = evicted_q;
		bound_d    = bound_q;
		len_d      = len_q;
		rd_en      = 1'b0;
		rd_addr    = head_q;
		wr_en      = 1'b0;
		emit       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					accepted_d = 1'b0;
					found_d    = 1'b0;
					slot_d     = '0;
					evicted_d  = '0;
					case (q_cmd.op)
						OP_APPEND: begin
							// Fetch the oldest length in case the ring is full
							rd_en      = 1'b1;
							len_d      = q_cmd.length;
							accepted_d = q_cmd.index == next_index;
						end
						OP_READ: begin
							rd_en   = 1'b1;
							rd_addr = head_q + read_off[SLOT_BITS-1:0];
							found_d = read_hit;
							slot_d  = read_hit ? rd_addr : '0;
						end
						OP_DROP: begin
							rd_en   = 1'b1;
							bound_d = q_cmd.index;
						end
						default: begin
							evicted_d = count_q;
							head_d    = '0;
							count_d   = '0;
							oldest_d  = '0;
							total_d   = '0;
						end
					endcase
				end
			end
			ST_APPEND: begin
				// Write the new chunk, popping the oldest first when full
				wr_en     = 1'b1;
				slot_d    = tail;
				head_d    = head_q + SLOT_BITS'(ring_full);
				oldest_d  = oldest_q + INDEX_BITS'(ring_full);
				count_d   = ring_full ? count_q : count_q + COUNT_BITS'(1);
				total_d   = total_q - (ring_full ? BYTES_BITS'(rd_q) : '0)
					+ BYTES_BITS'(len_q);
				evicted_d = COUNT_BITS'(ring_full);
				rd_en     = 1'b1;
				rd_addr   = head_d;
			end
			ST_EVICT, ST_DROP: begin
				if ((state_q == ST_EVICT) ? evict_go : drop_go) begin
					// Pop the oldest chunk and prefetch the next one
					total_d   = total_q - BYTES_BITS'(rd_q);
					head_d    = head_q + SLOT_BITS'(1);
					count_d   = count_q - COUNT_BITS'(1);
					oldest_d  = oldest_q + INDEX_BITS'(1);
					evicted_d = evicted_q + COUNT_BITS'(1);
					rd_en     = 1'b1;
					rd_addr   = head_d;
				end else begin
					emit = out_free;
				end
			end
			ST_READ, ST_DONE: emit = out_free;
			default: ;
		endcase
	end

	// Sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			oldest_q <= '0;
			total_q  <= '0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			count_q  <= count_d;
			oldest_q <= oldest_d;
			total_q  <= total_d;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		accepted_q <= accepted_d;
		found_q    <= found_d;
		slot_q     <= slot_d;
		evicted_q  <= evicted_d;
		bound_q    <= bound_d;
		len_q      <= len_d;
	end

	// Length memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			length_mem[tail] <= len_q;
		end
		if (rd_en) begin
			rd_q <= length_mem[rd_addr];
		end
	end

	// Result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result word payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.accepted     <= accepted_q;
			out_q.found        <= found_q;
			out_q.found_length <= found_q ? rd_q : '0;
			out_q.slot         <= slot_q;
			out_q.first_index  <= oldest_q;
			out_q.held_count   <= count_q;
			out_q.held_bytes   <= total_q;
			out_q.evicted      <= evicted_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.accepted     = out_q.accepted;
	assign rsp.found        = out_q.found;
	assign rsp.found_length = out_q.found_length;
	assign rsp.slot         = out_q.slot;
	assign rsp.first_index  = out_q.first_index;
	assign rsp.held_count   = out_q.held_count;
	assign rsp.held_bytes   = out_q.held_bytes;
	assign rsp.evicted      = out_q.evicted;

endmodule

[hw/rtl/chunk_window_byte_budget_core.sv]
// ----------------------------------------------------------------------------
// chunk_window_byte_budget_core: sliding chunk window with byte budget
// Tracks lengths of up to 64 consecutively numbered chunks in a ring and
// evicts the oldest ones when the ring is full or the byte total exceeds the budget.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  - command words (func, chunk_index, chunk_length): append, read,
//          drop below index, clear. Each word yields exactly one rsp word.
//   rsp  - result words in command order: accepted, found, found_length,
//          slot, first_index, held_count, held_bytes, evicted.
//   cfg  - register writes, always ready: index 0 chunk_size, index 1
//          capacity_bytes. Write only while no command is in flight.
// Sequencing:
//   A word passes an intake register and a two-word queue before the
//   engine, which takes the next word only once it is idle again. An
//   in-sequence append writes the chunk, popping the oldest one in the
//   same step when the ring is full, then evicts chunks for the byte
//   budget; a drop removes chunks one at a time. Eviction is paced by the
//   single read port of the length memory, one chunk per cycle, and every
//   chunk leaves once.
// Reset: window empty, first index 0, registers at chunk_size 1 and
//   capacity_bytes 65536. No clearing pass is needed.
// Stall: a held rsp word stalls the engine; the queue and intake register
//   keep taking cmd words until they fill, then cmd.ready drops.
// ----------------------------------------------------------------------------
module chunk_window_byte_budget_core import cwb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	cwb_cmd_if.sink   cmd,
	cwb_rsp_if.source rsp,
	cwb_cfg_if.sink   cfg
);

	logic [CHUNK_SIZE_BITS-1:0] chunk_size_q;
	logic [CAPACITY_BITS-1:0]   capacity_q;
	logic [CAPACITY_BITS-1:0]   cap_q;
	logic [CAPACITY_BITS-1:0]   chunk_floor;

	logic fq_valid;
	logic fq_ready;
	cmd_t fq_cmd;
	logic qe_valid;
	logic qe_ready;
	cmd_t qe_cmd;

	assign cfg.ready = 1'b1;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q <= CHUNK_SIZE_RESET;
			capacity_q   <= CAPACITY_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CHUNK_SIZE: chunk_size_q <= cfg.data[CHUNK_SIZE_BITS-1:0];
				REG_CAPACITY:   capacity_q   <= cfg.data[CAPACITY_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Effective capacity: larger of budget and chunk size, zero size counts as one
	assign chunk_floor = (chunk_size_q == '0) ? CAPACITY_BITS'(1)
		: CAPACITY_BITS'(chunk_size_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAPACITY_RESET;
		end else begin
			cap_q <= (capacity_q > chunk_floor) ? capacity_q : chunk_floor;
		end
	end

	cwb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_cmd   (fq_cmd)
	);

	cwb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_cmd    (fq_cmd),
		.out_valid (qe_valid),
		.out_ready (qe_ready),
		.out_cmd   (qe_cmd)
	);

	cwb_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (qe_valid),
		.q_ready (qe_ready),
		.q_cmd   (qe_cmd),
		.cap     (cap_q),
		.rsp     (rsp)
	);

endmodule

[dv/chunk_window_byte_budget_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chunk_window_byte_budget_core_tb: self-checking bench of the chunk window
// Drives append, read, drop and clear words under several register settings
// and random idling on both channels. A behavioral window model predicts
// every rsp word, and each word is checked field by field in order.
// ----------------------------------------------------------------------------
module chunk_window_byte_budget_core_tb;
	import cwb_pkg::*;

	localparam int HALF_PERIOD = 1;
	localparam int STALL_LIMIT = 4000;
	localparam int IDLE_PCT    = 8;

	logic clk = 1'b0;
	logic arst_n;

	cwb_cmd_if cmd ();
	cwb_rsp_if rsp ();
	cwb_cfg_if cfg ();

	chunk_window_byte_budget_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	always #HALF_PERIOD clk = ~clk;

	// Words waiting to be sent and rsp words predicted but not yet seen
	cmd_t cmd_backlog[$];
	rsp_t status_q[$];

	int  error_cnt = 0;
	int  idle_cycles = 0;
	bit  calm = 1'b0;

	// Next in-sequence index as seen by the stimulus generator
	logic [INDEX_BITS-1:0] plan_next = '0;

	// Shadow of the window and its registers
	logic [15:0]           reg_chunk_size = CHUNK_SIZE_RESET;
	logic [22:0]           reg_capacity   = CAPACITY_RESET;
	logic [LENGTH_BITS-1:0] len_mem[WINDOW_SLOTS];
	logic [SLOT_BITS-1:0]  w_head  = '0;
	int unsigned           w_cnt   = 0;
	logic [INDEX_BITS-1:0] w_first = '0;
	int unsigned           w_total = 0;

	// Retire the oldest chunk of the shadow window
	function automatic void retire_oldest();
		w_total = w_total - len_mem[w_head];
		w_head  = w_head + 1'b1;
		w_cnt   = w_cnt - 1;
		w_first = w_first + 1'b1;
	endfunction

	// Apply one command word to the shadow window and return its status
	function automatic rsp_t window_step(op_t op, logic [INDEX_BITS-1:0] idx,
			logic [LENGTH_BITS-1:0] len);
		rsp_t                  r;
		int unsigned           cs;
		int unsigned           eff_cap;
		logic [INDEX_BITS-1:0] next_idx;
		logic [INDEX_BITS-1:0] off;
		logic [SLOT_BITS-1:0]  new_slot;
		r = '0;
		case (op)
			OP_APPEND: begin
				next_idx = w_first + w_cnt;
				if (idx == next_idx) begin
					cs      = (reg_chunk_size == 0) ? 1 : reg_chunk_size;
					eff_cap = (reg_capacity > cs) ? reg_capacity : cs;
					// full ring: make room first
					if (w_cnt >= WINDOW_SLOTS) begin
						retire_oldest();
						r.evicted = r.evicted + 1'b1;
					end
					new_slot          = w_head + w_cnt[SLOT_BITS-1:0];
					len_mem[new_slot] = len;
					w_cnt             = w_cnt + 1;
					w_total           = w_total + len;
					// trim to the byte budget, keep the newest chunk
					while (w_total > eff_cap && w_cnt > 1) begin
						retire_oldest();
						r.evicted = r.evicted + 1'b1;
					end
					r.slot     = new_slot;
					r.accepted = 1'b1;
				end
			end
			OP_READ: begin
				off = idx - w_first;
				if (off < w_cnt) begin
					r.found        = 1'b1;
					r.slot         = w_head + off[SLOT_BITS-1:0];
					r.found_length = len_mem[r.slot];
				end
			end
			OP_DROP: begin
				while (w_first < idx && w_cnt > 0) begin
					retire_oldest();
					r.evicted = r.evicted + 1'b1;
				end
			end
			default: begin
				r.evicted = w_cnt[COUNT_BITS-1:0];
				w_cnt     = 0;
				w_first   = '0;
				w_total   = 0;
				w_head    = '0;
			end
		endcase
		r.first_index = w_first;
		r.held_count  = w_cnt[COUNT_BITS-1:0];
		r.held_bytes  = w_total[BYTES_BITS-1:0];
		return r;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			error_cnt++;
		end
	endfunction

	// Command driver: predict on acceptance, then present the next word
	always @(posedge clk or negedge arst_n) begin : drive_cmd
		cmd_t nxt;
		if (!arst_n) begin
			cmd.valid <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready)
				status_q.push_back(window_step(op_t'(cmd.func), cmd.chunk_index,
					cmd.chunk_length));
			if (!cmd.valid || cmd.ready) begin
				if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					nxt              = cmd_backlog.pop_front();
					cmd.valid        <= 1'b1;
					cmd.func         <= nxt.op;
					cmd.chunk_index  <= nxt.index;
					cmd.chunk_length <= nxt.length;
				end else begin
					cmd.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each accepted word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : watch_rsp
		rsp_t want;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (status_q.size() == 0) begin
					$display("%0t: unexpected rsp word, expected none, actual first_index 0x%0h",
						$time, rsp.first_index);
					error_cnt++;
				end else begin
					want = status_q.pop_front();
					compare_field("accepted", 32'(want.accepted), 32'(rsp.accepted));
					compare_field("found", 32'(want.found), 32'(rsp.found));
					compare_field("found_length", 32'(want.found_length),
						32'(rsp.found_length));
					compare_field("slot", 32'(want.slot), 32'(rsp.slot));
					compare_field("first_index", want.first_index, rsp.first_index);
					compare_field("held_count", 32'(want.held_count), 32'(rsp.held_count));
					compare_field("held_bytes", 32'(want.held_bytes), 32'(rsp.held_bytes));
					compare_field("evicted", 32'(want.evicted), 32'(rsp.evicted));
				end
			end
			rsp.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog: abort when work is outstanding but nothing moves
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) ||
					(cfg.valid && cfg.ready))
				idle_cycles <= 0;
			else if (cmd_backlog.size() != 0 || cmd.valid || status_q.size() != 0)
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Write one register; call right after a rising edge
	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk);
		while (!cfg.ready);
		if (idx == REG_CHUNK_SIZE)
			reg_chunk_size = val[15:0];
		else if (idx == REG_CAPACITY)
			reg_capacity = val;
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Hold until every sent word has its rsp word back; sample between
	// edges so the driver and monitor have settled, then realign to a
	// rising edge
	task automatic wait_drained();
		do @(negedge clk);
		while (cmd_backlog.size() != 0 || cmd.valid || status_q.size() != 0);
		@(posedge clk);
	endtask

	// Queue one word and track the next in-sequence index
	function automatic void queue_cmd(op_t op, logic [INDEX_BITS-1:0] idx,
			logic [LENGTH_BITS-1:0] len);
		cmd_t c;
		c.op     = op;
		c.index  = idx;
		c.length = len;
		cmd_backlog.push_back(c);
		if (op == OP_APPEND && idx == plan_next)
			plan_next = plan_next + 1'b1;
		else if (op == OP_CLEAR)
			plan_next = '0;
	endfunction

	function automatic logic [LENGTH_BITS-1:0] pick_length();
		case ($urandom_range(3))
			0: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
			1: return LENGTH_BITS'($urandom_range(1, 64));
			default: return LENGTH_BITS'($urandom_range(0, 65535));
		endcase
	endfunction

	// Mostly in-sequence appends with random lengths, plus reads, drops, noise
	function automatic void queue_random(int n, bit no_removal);
		int roll;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			if (roll < 55)
				queue_cmd(OP_APPEND, plan_next, pick_length());
			else if (roll < 62)
				queue_cmd(OP_APPEND, $urandom_range(1) ? $urandom() :
					plan_next - 1'b1 + 2 * $urandom_range(1), pick_length());
			else if (roll < 82 || no_removal)
				queue_cmd(OP_READ, $urandom_range(3) == 0 ? $urandom() :
					plan_next - $urandom_range(0, 70),
					LENGTH_BITS'($urandom_range(0, 65535)));
			else if (roll < 97)
				queue_cmd(OP_DROP, $urandom_range(7) == 0 ? $urandom() :
					plan_next - $urandom_range(0, 66),
					LENGTH_BITS'($urandom_range(0, 65535)));
			else
				queue_cmd(OP_CLEAR, $urandom(), LENGTH_BITS'($urandom_range(0, 65535)));
		end
	endfunction

	initial begin
		arst_n           = 1'b0;
		cmd.valid        = 1'b0;
		cmd.func         = OP_APPEND;
		cmd.chunk_index  = '0;
		cmd.chunk_length = '0;
		rsp.ready        = 1'b0;
		cfg.valid        = 1'b0;
		cfg.index        = REG_CHUNK_SIZE;
		cfg.data         = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass at reset settings: misses, out of sequence appends,
		// byte budget eviction, drops of every kind and clears
		queue_cmd(OP_READ,   32'd0,          16'd0);
		queue_cmd(OP_APPEND, 32'd1,          16'd5);
		queue_cmd(OP_APPEND, 32'd0,          16'd0);
		queue_cmd(OP_APPEND, 32'd0,          16'd7);
		queue_cmd(OP_APPEND, 32'd1,          16'hFFFF);
		queue_cmd(OP_READ,   32'd0,          16'd0);
		queue_cmd(OP_READ,   32'd1,          16'hFFFF);
		queue_cmd(OP_READ,   32'd2,          16'd0);
		queue_cmd(OP_READ,   32'hFFFF_FFFF,  16'd0);
		queue_cmd(OP_APPEND, 32'd2,          16'hFFFF);
		queue_cmd(OP_APPEND, 32'd3,          16'd1);
		queue_cmd(OP_APPEND, 32'd4,          16'd1);
		queue_cmd(OP_DROP,   32'd0,          16'd0);
		queue_cmd(OP_DROP,   32'd4,          16'd0);
		queue_cmd(OP_DROP,   32'hFFFF_FFFF,  16'd0);
		queue_cmd(OP_DROP,   32'd7,          16'd0);
		queue_cmd(OP_READ,   32'd4,          16'd0);
		queue_cmd(OP_APPEND, 32'd5,          16'd100);
		queue_cmd(OP_APPEND, 32'd6,          16'd200);
		queue_cmd(OP_CLEAR,  32'hFFFF_FFFF,  16'hFFFF);
		queue_cmd(OP_CLEAR,  32'd0,          16'd0);
		queue_cmd(OP_APPEND, 32'd0,          16'hAAAA);
		queue_cmd(OP_APPEND, 32'd1,          16'h5555);
		queue_cmd(OP_READ,   32'd1,          16'd0);
		wait_drained();

		// Widest budget, zero chunk size: only the full ring evicts; no idling
		write_reg(REG_CAPACITY, 23'd4194304);
		write_reg(REG_CHUNK_SIZE, {7'h7F, 16'h0000});
		calm = 1'b1;
		queue_random(250, 1'b1);
		wait_drained();
		calm = 1'b0;

		// Chunk size above capacity sets the budget
		write_reg(REG_CAPACITY, 23'd0);
		write_reg(REG_CHUNK_SIZE, 23'd65535);
		queue_random(200, 1'b0);
		wait_drained();

		// Both zero: the budget is one byte, so each append trims the window to at most one byte or to itself alone
		write_reg(REG_CHUNK_SIZE, 23'd0);
		queue_random(120, 1'b0);
		wait_drained();

		// Random settings
		for (int p = 0; p < 2; p++) begin
			write_reg(REG_CHUNK_SIZE, CFG_DATA_BITS'($urandom_range(0, 23'h7FFFFF)));
			write_reg(REG_CAPACITY, CFG_DATA_BITS'($urandom_range(0, 4194304)));
			queue_random(200, 1'b0);
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (error_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
